@@ hdl/asrf_pkg.sv @@
package asrf_pkg;

	// Default widths of the tick counter, the phase lengths and the fraction
	localparam int TICK_BITS_DEF = 32;
	localparam int LEN_BITS_DEF  = 24;
	localparam int FRAC_BITS_DEF = 8;

	// Factor field width and the width that holds 1.0 at the widest fraction
	localparam int FACTOR_BITS = 16;
	localparam int MAG_BITS    = FACTOR_BITS + 1;
	localparam int PHASE_BITS  = 2;

	typedef enum logic [PHASE_BITS-1:0] {
		PH_ATTACK   = 2'd0,
		PH_SUSTAIN  = 2'd1,
		PH_RELEASE  = 2'd2,
		PH_FINISHED = 2'd3
	} phase_t;

	typedef enum logic {
		CMD_TRIGGER = 1'b0,
		CMD_FRAME   = 1'b1
	} command_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ATTACK,
		ST_SUSTAIN,
		ST_RELEASE,
		ST_MUL,
		ST_DSTART,
		ST_DWAIT,
		ST_OUT
	} state_t;

endpackage

@@ hdl/asrf_if.sv @@
interface asrf_in_if #(
	parameter int TICK_BITS = asrf_pkg::TICK_BITS_DEF,
	parameter int LEN_BITS  = asrf_pkg::LEN_BITS_DEF
);
	import asrf_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   command;
	logic [TICK_BITS-1:0]   now_ticks;
	logic [LEN_BITS-1:0]    attack_ticks;
	logic [LEN_BITS-1:0]    sustain_ticks;
	logic [LEN_BITS-1:0]    release_ticks;
	logic [FACTOR_BITS-1:0] target_factor;

	modport source (
		output valid, command, now_ticks, attack_ticks, sustain_ticks, release_ticks,
			target_factor,
		input  ready
	);
	modport sink (
		input  valid, command, now_ticks, attack_ticks, sustain_ticks, release_ticks,
			target_factor,
		output ready
	);
endinterface

interface asrf_out_if;
	import asrf_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [FACTOR_BITS-1:0] time_factor;
	logic [PHASE_BITS-1:0]  phase;
	logic                   still_active;

	modport source (
		output valid, time_factor, phase, still_active,
		input  ready
	);
	modport sink (
		input  valid, time_factor, phase, still_active,
		output ready
	);
endinterface

@@ hdl/asrf_div.sv @@
module asrf_div #(
	parameter int LEN_BITS = asrf_pkg::LEN_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	input  logic [asrf_pkg::MAG_BITS+LEN_BITS-1:0]    dividend,
	input  logic [LEN_BITS-1:0]                       divisor,
	output logic                                      done,
	output logic [asrf_pkg::MAG_BITS-1:0]             quotient
);
	import asrf_pkg::*;

	localparam int PROD_BITS = MAG_BITS + LEN_BITS;
	localparam int CNT_BITS  = $clog2(MAG_BITS + 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [LEN_BITS-1:0] rem_q;
	logic [LEN_BITS-1:0] den_q;
	logic [MAG_BITS-1:0] quo_q;

	logic [LEN_BITS:0]   trial;
	logic [LEN_BITS:0]   diff;
	logic                ge;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, quo_q[MAG_BITS-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(MAG_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The upper part of the dividend is below the divisor, so the quotient fits MAG_BITS
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[PROD_BITS-1:MAG_BITS];
			quo_q <= dividend[MAG_BITS-1:0];
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
			quo_q <= {quo_q[MAG_BITS-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hdl/attack_sustain_release_factor.sv @@
// Attack-sustain-release envelope on a time-scale factor in unsigned fixed point
// (Q8.8 by default, 1.0 = 1 << FRAC_BITS). A trigger transfer (command 0) stores
// the current tick, the three phase lengths and the target level, arms the
// envelope and gives no result; the block stays idle. A frame transfer (command 1)
// while armed gives one result: the factor ramps linearly from 1.0 to the target
// during attack, holds the target during sustain, ramps back to 1.0 during
// release and is 1.0 once the envelope is over, which disarms it. A frame while
// disarmed is taken and dropped. Elapsed time is modular in TICK_BITS and ramp
// quotients truncate toward the start value. The block works on one transfer at a
// time: the input is ready only in idle. The phase is found by one shared
// subtractor, one length per cycle; a ramp frame then goes through the multiply
// and the shift-subtract divider with its MAG_BITS (17) bit quotient, while
// sustain and finished frames skip both. A result sits in the output register
// until taken, and the next transfer is accepted meanwhile.
module attack_sustain_release_factor #(
	parameter int TICK_BITS = asrf_pkg::TICK_BITS_DEF,
	parameter int LEN_BITS  = asrf_pkg::LEN_BITS_DEF,
	parameter int FRAC_BITS = asrf_pkg::FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	asrf_in_if.sink    in_ch,
	asrf_out_if.source out_ch
);
	import asrf_pkg::*;

	localparam int CMP_BITS  = (TICK_BITS > LEN_BITS) ? TICK_BITS : LEN_BITS;
	localparam int PROD_BITS = MAG_BITS + LEN_BITS;
	localparam logic [MAG_BITS-1:0] ONE = {{(MAG_BITS-1){1'b0}}, 1'b1} << FRAC_BITS;

	state_t state_q, state_d;

	// Envelope state
	logic                 active_q;
	logic [TICK_BITS-1:0] start_q;
	logic [LEN_BITS-1:0]  atk_q;
	logic [LEN_BITS-1:0]  sus_q;
	logic [LEN_BITS-1:0]  rel_q;
	logic [MAG_BITS-1:0]  level_q;

	// Per-frame working registers
	logic [CMP_BITS-1:0]  elapsed_q;
	phase_t               phase_q;
	logic [MAG_BITS-1:0]  factor_q;
	logic [PROD_BITS-1:0] prod_q;

	// Output register
	logic                   out_valid_q;
	logic [FACTOR_BITS-1:0] out_factor_q;
	phase_t                 out_phase_q;
	logic                   out_active_q;

	// FSM outputs
	logic in_ready;
	logic div_start;
	logic out_load;

	logic                 accept;
	logic [CMP_BITS-1:0]  cur_len;
	logic [CMP_BITS:0]    step_diff;
	logic                 in_phase;
	logic                 level_hi;
	logic [MAG_BITS-1:0]  mag;
	logic [LEN_BITS-1:0]  divisor;
	logic                 div_done;
	logic [MAG_BITS-1:0]  quotient;
	logic [MAG_BITS-1:0]  ramp_val;

	assign accept = in_ch.valid && in_ready;

	// Shared subtractor: borrow means the elapsed time lies inside the current phase
	always_comb begin
		case (state_q)
			ST_ATTACK:  cur_len = CMP_BITS'(atk_q);
			ST_SUSTAIN: cur_len = CMP_BITS'(sus_q);
			default:    cur_len = CMP_BITS'(rel_q);
		endcase
		step_diff = {1'b0, elapsed_q} - {1'b0, cur_len};
		in_phase  = step_diff[CMP_BITS];
	end

	// Ramp magnitude |level - 1.0| and the length that divides it
	always_comb begin
		level_hi = (level_q >= ONE);
		mag      = level_hi ? (level_q - ONE) : (ONE - level_q);
		divisor  = (phase_q == PH_RELEASE) ? rel_q : atk_q;
	end

	// Attack runs from 1.0 toward the level, release from the level back to 1.0
	always_comb begin
		if (phase_q == PH_RELEASE) begin
			ramp_val = level_hi ? (level_q - quotient) : (level_q + quotient);
		end else begin
			ramp_val = level_hi ? (ONE + quotient) : (ONE - quotient);
		end
	end

	asrf_div #(
		.LEN_BITS (LEN_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_ch.command == CMD_FRAME && active_q)
					state_d = ST_ATTACK;
			end
			ST_ATTACK: begin
				state_d = in_phase ? ST_MUL : ST_SUSTAIN;
			end
			ST_SUSTAIN: begin
				state_d = in_phase ? ST_OUT : ST_RELEASE;
			end
			ST_RELEASE: begin
				state_d = in_phase ? ST_MUL : ST_OUT;
			end
			ST_MUL:    state_d = ST_DSTART;
			ST_DSTART: state_d = ST_DWAIT;
			ST_DWAIT: begin
				if (div_done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ch.ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready  = 1'b1;
			ST_DSTART: div_start = 1'b1;
			ST_OUT:    out_load  = !out_valid_q || out_ch.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= 1'b0;
			start_q     <= '0;
			atk_q       <= '0;
			sus_q       <= '0;
			rel_q       <= '0;
			level_q     <= ONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Trigger: latch the envelope and arm it
			if (accept && in_ch.command == CMD_TRIGGER) begin
				start_q  <= in_ch.now_ticks;
				atk_q    <= in_ch.attack_ticks;
				sus_q    <= in_ch.sustain_ticks;
				rel_q    <= in_ch.release_ticks;
				level_q  <= MAG_BITS'(in_ch.target_factor);
				active_q <= 1'b1;
			end
			// Past the end of release: disarm
			if (state_q == ST_RELEASE && !in_phase)
				active_q <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	// Frame datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				// Wrap the difference at the tick width before widening it
				elapsed_q <= CMP_BITS'(TICK_BITS'(in_ch.now_ticks - start_q));
			end
			ST_ATTACK: begin
				phase_q <= PH_ATTACK;
				if (!in_phase)
					elapsed_q <= step_diff[CMP_BITS-1:0];
			end
			ST_SUSTAIN: begin
				phase_q  <= PH_SUSTAIN;
				factor_q <= level_q;
				if (!in_phase)
					elapsed_q <= step_diff[CMP_BITS-1:0];
			end
			ST_RELEASE: begin
				phase_q  <= in_phase ? PH_RELEASE : PH_FINISHED;
				factor_q <= ONE;
			end
			ST_MUL: begin
				// Elapsed time is below the phase length here, so it fits LEN_BITS
				prod_q <= PROD_BITS'(mag) * PROD_BITS'(elapsed_q[LEN_BITS-1:0]);
			end
			ST_DWAIT: begin
				if (div_done)
					factor_q <= ramp_val;
			end
			default: ;
		endcase
		// Saturate to the factor field on load
		if (out_load) begin
			out_factor_q <= (factor_q[MAG_BITS-1:FACTOR_BITS] != '0) ? '1
				: factor_q[FACTOR_BITS-1:0];
			out_phase_q  <= phase_q;
			out_active_q <= active_q;
		end
	end

	assign in_ch.ready         = in_ready;
	assign out_ch.valid        = out_valid_q;
	assign out_ch.time_factor  = out_factor_q;
	assign out_ch.phase        = out_phase_q;
	assign out_ch.still_active = out_active_q;

endmodule

@@ dv/asrf_factor_checker.sv @@
`timescale 1ns / 100ps

module asrf_factor_checker
	import asrf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	asrf_in_if   in_mon,
	asrf_out_if  out_mon,
	output int   fail_count,
	output int   pending,
	output int   checked_count
);

	localparam int TB = TICK_BITS_DEF;
	localparam int LB = LEN_BITS_DEF;
	localparam logic [FACTOR_BITS-1:0] UNITY = FACTOR_BITS'(1 << FRAC_BITS_DEF);
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [FACTOR_BITS-1:0] time_factor;
		phase_t                 phase;
		logic                   still_active;
	} factor_result_t;

	factor_result_t expected_factors[$];

	// shadow envelope state
	logic                   env_armed;
	logic [TB-1:0]          env_start;
	logic [LB-1:0]          attack_len;
	logic [LB-1:0]          sustain_len;
	logic [LB-1:0]          release_len;
	logic [FACTOR_BITS-1:0] env_level;

	int errors;
	int checked;

	// from + sign(to - from) * trunc(|to - from| * num / den), clamped to the field
	function automatic logic [FACTOR_BITS-1:0] ramp_between(longint from_v, longint to_v,
			longint num, longint den);
		longint diff;
		longint mag;
		longint q;
		longint v;
		diff = to_v - from_v;
		mag  = (diff < 0) ? -diff : diff;
		q    = (mag * num) / den;
		v    = (diff < 0) ? from_v - q : from_v + q;
		if (v < 0)
			return '0;
		if (v > 65535)
			return '1;
		return v[FACTOR_BITS-1:0];
	endfunction

	function automatic factor_result_t envelope_frame(logic [TB-1:0] now);
		factor_result_t r;
		logic [TB-1:0]  elapsed;
		elapsed = now - env_start;
		r.still_active = 1'b1;
		if (elapsed < TB'(attack_len)) begin
			r.time_factor = ramp_between(UNITY, env_level, elapsed, attack_len);
			r.phase       = PH_ATTACK;
		end else begin
			elapsed -= TB'(attack_len);
			if (elapsed < TB'(sustain_len)) begin
				r.time_factor = env_level;
				r.phase       = PH_SUSTAIN;
			end else begin
				elapsed -= TB'(sustain_len);
				if (elapsed < TB'(release_len)) begin
					r.time_factor = ramp_between(env_level, UNITY, elapsed, release_len);
					r.phase       = PH_RELEASE;
				end else begin
					r.time_factor  = UNITY;
					r.phase        = PH_FINISHED;
					r.still_active = 1'b0;
					env_armed      = 1'b0;
				end
			end
		end
		return r;
	endfunction

	task automatic flag_error(string msg);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("%0t ns: ERROR %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		factor_result_t exp_r;
		if (!arst_n) begin
			expected_factors.delete();
			env_armed   = 1'b0;
			env_start   = '0;
			attack_len  = '0;
			sustain_len = '0;
			release_len = '0;
			env_level   = UNITY;
			errors      = 0;
			checked     = 0;
		end else begin
			// retire the result first: a frame taken on this edge is always younger
			if (out_mon.valid && out_mon.ready) begin
				if (expected_factors.size() == 0) begin
					flag_error($sformatf("unexpected result factor=%h phase=%0d active=%b",
						out_mon.time_factor, out_mon.phase, out_mon.still_active));
				end else begin
					exp_r = expected_factors.pop_front();
					checked++;
					if (exp_r.time_factor !== out_mon.time_factor ||
							PHASE_BITS'(exp_r.phase) !== out_mon.phase ||
							exp_r.still_active !== out_mon.still_active)
						flag_error($sformatf(
							"result %0d: expected factor=%h phase=%0d active=%b, got factor=%h phase=%0d active=%b",
							checked, exp_r.time_factor, exp_r.phase, exp_r.still_active,
							out_mon.time_factor, out_mon.phase, out_mon.still_active));
				end
			end
			if (in_mon.valid && in_mon.ready) begin
				if (in_mon.command == CMD_TRIGGER) begin
					env_start   = in_mon.now_ticks;
					attack_len  = in_mon.attack_ticks;
					sustain_len = in_mon.sustain_ticks;
					release_len = in_mon.release_ticks;
					env_level   = in_mon.target_factor;
					env_armed   = 1'b1;
				end else if (env_armed) begin
					expected_factors.push_back(envelope_frame(in_mon.now_ticks));
				end
			end
		end
		fail_count    <= errors;
		pending       <= expected_factors.size();
		checked_count <= checked;
	end

endmodule

@@ dv/attack_sustain_release_factor_tb.sv @@
`timescale 1ns / 100ps

module attack_sustain_release_factor_tb;
	import asrf_pkg::*;

	localparam int  CLK_PERIOD  = 10;
	localparam int  ITEM_COUNT  = 1800;
	// slowest run is roughly 1800 items with the longest gap, busy time and stall each, about 1 ms
	localparam int  TIMEOUT_NS  = 5_000_000;
	localparam int  DRAIN_CYCLES = 40;
	localparam logic [FACTOR_BITS-1:0] UNITY = FACTOR_BITS'(1 << FRAC_BITS_DEF);

	logic clk = 1'b0;
	logic arst_n;

	asrf_in_if  in_ch ();
	asrf_out_if out_ch ();

	int fail_count;
	int pending;
	int checked_count;

	int triggers_sent = 0;
	int frames_sent   = 0;
	// while set, both sides run back to back with no idle cycles
	bit steady_flow   = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	attack_sustain_release_factor uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	asrf_factor_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_mon        (in_ch),
		.out_mon       (out_ch),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked_count (checked_count)
	);

	// Present one item and hold it until the block takes it. Lower valid only when
	// a gap is drawn, so valid gets a single update per time step.
	task automatic drive_item(command_t cmd, logic [31:0] now, logic [23:0] att,
			logic [23:0] sus, logic [23:0] rel, logic [15:0] target);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.command       <= cmd;
		in_ch.now_ticks     <= now;
		in_ch.attack_ticks  <= att;
		in_ch.sustain_ticks <= sus;
		in_ch.release_ticks <= rel;
		in_ch.target_factor <= target;
		do @(posedge clk); while (!in_ch.ready);
		if (cmd == CMD_TRIGGER)
			triggers_sent++;
		else
			frames_sent++;
	endtask

	task automatic send_trigger(logic [31:0] now, logic [23:0] att, logic [23:0] sus,
			logic [23:0] rel, logic [15:0] target);
		drive_item(CMD_TRIGGER, now, att, sus, rel, target);
	endtask

	// Frames ignore the envelope fields; fill them with junk so they get exercised.
	task automatic send_frame(logic [31:0] now);
		drive_item(CMD_FRAME, now, 24'($urandom), 24'($urandom), 24'($urandom),
			16'($urandom));
	endtask

	// Mostly short phases so frames land in every phase, with zero, full-range and
	// maximum lengths mixed in.
	function automatic logic [23:0] pick_length();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 24'($urandom);
			2: return '1;
			default: return 24'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic logic [15:0] pick_target();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return UNITY;
			default: return 16'($urandom);
		endcase
	endfunction

	// Result side: draw a stall for each result, then take it once valid shows up.
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// Stimulus
	initial begin
		logic [23:0] att, sus, rel;
		logic [31:0] start;
		longint      span;
		longint      offset;
		int          n_frames;

		arst_n              <= 1'b0;
		in_ch.valid         <= 1'b0;
		in_ch.command       <= CMD_TRIGGER;
		in_ch.now_ticks     <= '0;
		in_ch.attack_ticks  <= '0;
		in_ch.sustain_ticks <= '0;
		in_ch.release_ticks <= '0;
		in_ch.target_factor <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// Frame straight out of reset: nothing armed, so drop it silently.
		send_frame(32'h0000_1234);

		// Full-scale target across a counter wrap: two frames in attack, one in sustain
		// and three in release.
		send_trigger(32'hFFFF_FFF0, 24'd16, 24'd8, 24'd16, 16'hFFFF);
		send_frame(32'hFFFF_FFF0);
		send_frame(32'hFFFF_FFF5);
		send_frame(32'h0000_0000);
		send_frame(32'h0000_000D);
		send_frame(32'h0000_0010);
		send_frame(32'h0000_0011);

		// Maximum lengths down to a zero target: last tick of attack, first of
		// sustain, last of release, then an elapsed time far past the end.
		send_trigger(32'h0000_0000, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 16'h0000);
		send_frame(32'h00FF_FFFE);
		send_frame(32'h00FF_FFFF);
		send_frame(32'h02FF_FFFC);
		send_frame(32'hFFFF_FFFF);

		// All phases zero length: the first frame finishes at once.
		send_trigger(32'h8000_0000, 24'd0, 24'd0, 24'd0, 16'h1234);
		send_frame(32'h8000_0000);

		// Skip attack and sustain; release from a level equal to 1.0.
		send_trigger(32'h0000_0010, 24'd0, 24'd0, 24'd100, UNITY);
		send_frame(32'h0000_0020);

		// Downward attack ramp, then restart the envelope while it is still active.
		send_trigger(32'h0000_0100, 24'd50, 24'd0, 24'd50, 16'h0080);
		send_frame(32'h0000_0120);
		send_trigger(32'h0000_0200, 24'd10, 24'd10, 24'd10, 16'hFFFF);
		send_frame(32'h0000_020F);
		send_frame(32'h0000_0218);

		// Random part: mostly trigger-then-frames sequences with rising tick counts,
		// plus stray frames at arbitrary ticks that may find the envelope disarmed.
		while (triggers_sent + frames_sent < ITEM_COUNT) begin
			if ($urandom_range(0, 19) == 0)
				steady_flow = !steady_flow;
			if ($urandom_range(0, 9) == 0) begin
				send_frame($urandom);
			end else begin
				att   = pick_length();
				sus   = pick_length();
				rel   = pick_length();
				start = $urandom;
				send_trigger(start, att, sus, rel, pick_target());
				span     = longint'(att) + longint'(sus) + longint'(rel) + 8;
				n_frames = $urandom_range(1, 10);
				offset   = 0;
				repeat (n_frames) begin
					send_frame(start + 32'(offset));
					offset += $urandom_range(0, 32'(span / 3));
				end
			end
		end
		in_ch.valid <= 1'b0;

		// Let the last frame reach the checker, drain it, then idle so a trailing
		// result from a dropped frame would still be seen.
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d triggers and %0d frames; %0d factor results compared.",
			triggers_sent, frames_sent, checked_count);
		if (fail_count == 0 && pending == 0) begin
			$display("attack_sustain_release_factor test passed");
		end else begin
			$display("attack_sustain_release_factor test failed");
		end
		$finish;
	end

	// Hard stop if the block hangs.
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d results still outstanding.", pending);
		$display("attack_sustain_release_factor test failed");
		$finish;
	end

endmodule

@@ files.f @@
hdl/asrf_pkg.sv
hdl/asrf_if.sv
hdl/asrf_div.sv
hdl/attack_sustain_release_factor.sv
dv/asrf_factor_checker.sv
dv/attack_sustain_release_factor_tb.sv
